[rtl/llms_pkg.sv]
// llms_pkg: shared constants and types for the largest-label mask select block
// no dependencies; used by the stream interfaces, llms_hist and largest_label_mask_select
`timescale 1ns / 1ps

package llms_pkg;

  // fixed payload widths of the ports
  localparam int LABEL_W = 8;

  // default configuration of the histogram
  localparam int LABEL_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF = 21;

  // op field codes
  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // access request from the sequencer to the histogram unit
  typedef struct packed {
    logic cnt;   // count pixel: read, increment, write back
    logic scan;  // plain read for the winner search
    logic clr;   // write zero
  } hist_op_t;

endpackage

[rtl/llms_stream_if.sv]
// llms_in_if / llms_out_if: valid/ready channels carrying one pixel word and one mask word
// depends on llms_pkg for the label width
`timescale 1ns / 1ps

interface llms_in_if
  import llms_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [LABEL_W-1:0] label;
  logic               last;

  modport source (output valid, op, label, last, input ready);
  modport sink   (input valid, op, label, last, output ready);
endinterface

interface llms_out_if
  import llms_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               selected;
  logic [LABEL_W-1:0] chosen_label;
  logic               last_out;

  modport source (output valid, selected, chosen_label, last_out, input ready);
  modport sink   (input valid, selected, chosen_label, last_out, output ready);
endinterface

[rtl/llms_ram.sv]
// llms_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module llms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/llms_hist.sv]
// llms_hist: label histogram in RAM with read-modify-write increment and forwarding
// depends on llms_pkg (hist_op_t) and llms_ram
`timescale 1ns / 1ps

module llms_hist
  import llms_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hist_op_t              op,
  input  logic [LABEL_BITS-1:0] addr,
  output logic [COUNT_BITS-1:0] rd_data
);

  localparam int DEPTH = 1 << LABEL_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  rd_en;
  logic                  wr_en;
  logic [LABEL_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;

  logic                  s1_valid_r;
  logic [LABEL_BITS-1:0] s1_addr_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  // one read port shared by count and scan
  assign rd_en = op.cnt | op.scan;

  // count pipeline: read issued on accept, update written in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= op.cnt;
      fwd_hit_r  <= rd_en && wr_en && (wr_addr == addr);
    end
    s1_addr_r  <= addr;
    fwd_data_r <= wr_data;
  end

  // a write to the entry read at the same edge bypasses the stale ram data
  assign cur = fwd_hit_r ? fwd_data_r : ram_rdata;

  // saturating increment
  assign inc = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  // write port: clear sweep or count update
  assign wr_en   = op.clr | s1_valid_r;
  assign wr_addr = op.clr ? addr : s1_addr_r;
  assign wr_data = op.clr ? '0 : inc;

  assign rd_data = cur;

  llms_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (addr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/largest_label_mask_select.sv]
// largest_label_mask_select: two-pass label histogram and largest-label mask generator
// depends on llms_pkg, llms_stream_if and llms_hist
//
// Pixels arrive as words on the input channel. Count words (op = 0) bump their label's
// histogram entry and produce nothing; select words (op = 1) each produce one mask word
// whose selected bit says whether the pixel carries the most frequent nonzero label
// (smallest label on a tie, label 0 if no nonzero label was counted). Count and select
// words are taken at one per cycle while the mask word register is free. The first select
// word of a pass stalls the input while the winner is searched one histogram entry per cycle
// through the single RAM read port. After the select word marked last, and after reset,
// the histogram RAM is cleared one entry per cycle, during which no input word is taken.
// Counts saturate at 2^COUNT_BITS - 1.
`timescale 1ns / 1ps

module largest_label_mask_select
  import llms_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  llms_in_if.sink    in_word,
  llms_out_if.source out_word
);

  localparam logic [LABEL_BITS-1:0] LAST_IDX = {LABEL_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [LABEL_BITS-1:0] idx_r;
  logic                  scan_issue_r;
  logic                  sv_valid_r;
  logic [LABEL_BITS-1:0] sv_addr_r;
  logic [COUNT_BITS-1:0] top_r;
  logic [LABEL_BITS-1:0] win_r;
  logic [LABEL_BITS-1:0] best_label_r;
  logic                  best_valid_r;
  logic [LABEL_BITS-1:0] hold_label_r;
  logic                  hold_last_r;
  logic                  out_valid_r;
  logic                  out_sel_r;
  logic [LABEL_W-1:0]    out_chosen_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  out_load;
  logic                  acc;
  logic [LABEL_BITS-1:0] lab;
  logic                  better;
  hist_op_t              hop;
  logic [LABEL_BITS-1:0] haddr;
  logic [COUNT_BITS-1:0] hdata;

  // handshake
  assign out_free      = !out_valid_r || out_word.ready;
  assign in_word.ready = (state_r == ST_RUN) && out_free;
  assign acc           = in_word.valid && in_word.ready;
  assign lab           = LABEL_BITS'(in_word.label);

  // a mask word is loaded on a select word with a frozen choice or at the end of a search
  assign out_load = ((state_r == ST_RUN) && acc && (in_word.op == OP_SELECT) && best_valid_r)
                 || ((state_r == ST_EMIT) && out_free);

  // histogram requests
  always_comb begin
    hop.cnt  = acc && (in_word.op == OP_COUNT);
    hop.scan = (state_r == ST_SCAN) && scan_issue_r;
    hop.clr  = (state_r == ST_CLEAR);
    haddr    = (state_r == ST_RUN) ? lab : idx_r;
  end

  // strict compare keeps the smallest label on a tie
  assign better = hdata > top_r;

  // sequencer, winner search and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      scan_issue_r <= 1'b0;
      sv_valid_r   <= 1'b0;
      best_label_r <= '0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // output word valid
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      sv_valid_r <= hop.scan;
      sv_addr_r  <= idx_r;
      unique case (state_r)
        ST_CLEAR: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= ST_RUN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_RUN: begin
          if (acc && (in_word.op == OP_SELECT)) begin
            if (best_valid_r) begin
              out_sel_r    <= (lab == best_label_r);
              out_chosen_r <= LABEL_W'(best_label_r);
              out_last_r   <= in_word.last;
              if (in_word.last) begin
                best_valid_r <= 1'b0;
                idx_r        <= '0;
                state_r      <= ST_CLEAR;
              end
            end else begin
              // search entries 1 .. last, label 0 never competes
              hold_label_r <= lab;
              hold_last_r  <= in_word.last;
              idx_r        <= LABEL_BITS'(1);
              scan_issue_r <= 1'b1;
              top_r        <= '0;
              win_r        <= '0;
              state_r      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue_r) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == LAST_IDX) begin
              scan_issue_r <= 1'b0;
            end
          end
          if (sv_valid_r && better) begin
            top_r <= hdata;
            win_r <= sv_addr_r;
          end
          if (sv_valid_r && (sv_addr_r == LAST_IDX)) begin
            best_label_r <= better ? sv_addr_r : win_r;
            best_valid_r <= 1'b1;
            state_r      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_sel_r    <= (hold_label_r == best_label_r);
            out_chosen_r <= LABEL_W'(best_label_r);
            out_last_r   <= hold_last_r;
            idx_r        <= '0;
            if (hold_last_r) begin
              best_valid_r <= 1'b0;
              state_r      <= ST_CLEAR;
            end else begin
              state_r <= ST_RUN;
            end
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          idx_r   <= '0;
        end
      endcase
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.selected     = out_sel_r;
  assign out_word.chosen_label = out_chosen_r;
  assign out_word.last_out     = out_last_r;

  llms_hist #(
    .LABEL_BITS (LABEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (hop),
    .addr    (haddr),
    .rd_data (hdata)
  );

endmodule
